### rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared sizes, command codes and controller/datapath interface types for
// the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int SLOTS          = 16384;
    localparam int MAX_READ_CHUNK = 64;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 14;
    localparam int CNT_W  = 14;
    localparam int CMD_W  = 3;
    // arithmetic width for counts: holds SLOTS and any index plus any length
    localparam int CALC_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int LEFT_W = $clog2(MAX_READ_CHUNK + 1);

    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd4;

    typedef struct packed {
        logic accept;      // input item taken this cycle
        logic imm_load;    // load a single immediate result
        logic imm_acc;     // accepted flag of that result (non-put)
        logic do_put;
        logic do_clear;
        logic start_read;  // load read pointer and byte count
        logic rd_commit;   // get: move the read index past the bytes
        logic issue;       // read one byte from the store
        logic issue_last;
    } ctrl_t;

    typedef struct packed {
        logic s1_valid;     // read data stage holds a byte
        logic s1_free_next; // read data stage can take a byte next cycle
        logic out_free;     // output register can be loaded
        logic read_len_ok;  // get/peek length within limits
        logic len_zero;
        logic left_last;    // one byte left to issue
    } status_t;

endpackage

### rtl/byte_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_top
// Put, clear, status, rejected items: one per cycle while the output is free,
// result in the cycle after acceptance. Get/peek of n bytes: first byte via
// read data stage and output register, then one per cycle while the output
// is free, set by the single store read port; new items wait until the last
// byte left the read stage. Reset clears indexes, chunk state, not the store.
// ----------------------------------------------------------------------------
module byte_ring_buffer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [brb_pkg::CMD_W-1:0]     s_command,
    input  logic [brb_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic [brb_pkg::LEN_W-1:0]     s_length,
    input  logic                          s_first_of_chunk,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [brb_pkg::BYTE_W-1:0]    m_read_byte,
    output logic                          m_last,
    output logic                          m_accepted,
    output logic [brb_pkg::CNT_W-1:0]     m_used_count,
    output logic [brb_pkg::CNT_W-1:0]     m_free_count,
    output logic [brb_pkg::CNT_W-1:0]     m_contiguous_put,
    output logic [brb_pkg::CNT_W-1:0]     m_contiguous_get
);

    brb_pkg::ctrl_t   ctrl;
    brb_pkg::status_t status;

    brb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .status    (status),
        .ctrl      (ctrl)
    );

    brb_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_data_byte      (s_data_byte),
        .s_length         (s_length),
        .s_first_of_chunk (s_first_of_chunk),
        .ctrl             (ctrl),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_byte      (m_read_byte),
        .m_last           (m_last),
        .m_accepted       (m_accepted),
        .m_used_count     (m_used_count),
        .m_free_count     (m_free_count),
        .m_contiguous_put (m_contiguous_put),
        .m_contiguous_get (m_contiguous_get)
    );

`ifndef NO_ASSERTIONS
    // a read burst blocks new items until it is done
    a_read_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start_read |=> !s_ready)
        else $error("item accepted during a read burst");

    // a store read only when the read data stage has room for its byte
    a_issue_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.issue |-> status.s1_free_next)
        else $error("store read issued with no room in read data stage");

    // an immediate result never competes with a pending read byte
    a_imm_no_byte_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.imm_load |-> (!status.s1_valid && !ctrl.issue))
        else $error("immediate result while a read byte is pending");

    // a byte in the read data stage reaches the output in the next cycle when the output is free
    a_byte_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.s1_valid && status.out_free) |=> m_valid)
        else $error("read byte lost between stage and output");
`endif

endmodule

### rtl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Command decode and read sequencer: idle accepts items, read issues one
// store read per cycle while the read data stage has room.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [brb_pkg::CMD_W-1:0]    s_command,
    input  brb_pkg::status_t             status,
    output brb_pkg::ctrl_t               ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        ctrl       = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = !status.s1_valid && status.out_free;
                ctrl.accept = s_valid && s_ready;
                if (ctrl.accept) begin
                    case (s_command)
                        brb_pkg::CMD_PUT: begin
                            ctrl.imm_load = 1'b1;
                            ctrl.do_put   = 1'b1;
                        end
                        brb_pkg::CMD_GET, brb_pkg::CMD_PEEK: begin
                            if (!status.read_len_ok) begin
                                ctrl.imm_load = 1'b1;
                            end else if (status.len_zero) begin
                                ctrl.imm_load = 1'b1;
                                ctrl.imm_acc  = 1'b1;
                            end else begin
                                ctrl.start_read = 1'b1;
                                ctrl.rd_commit  = (s_command == brb_pkg::CMD_GET);
                                state_next      = ST_READ;
                            end
                        end
                        brb_pkg::CMD_CLEAR: begin
                            ctrl.imm_load = 1'b1;
                            ctrl.imm_acc  = 1'b1;
                            ctrl.do_clear = 1'b1;
                        end
                        brb_pkg::CMD_STATUS: begin
                            ctrl.imm_load = 1'b1;
                            ctrl.imm_acc  = 1'b1;
                        end
                        default: begin
                            ctrl.imm_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                ctrl.issue      = status.s1_free_next;
                ctrl.issue_last = status.left_last;
                if (ctrl.issue && status.left_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/brb_datapath.sv
// ----------------------------------------------------------------------------
// brb_datapath
// Byte store, ring indexes, put chunk tracking, read data stage and the
// output register with the fill level counts.
// ----------------------------------------------------------------------------
module brb_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [brb_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic [brb_pkg::LEN_W-1:0]     s_length,
    input  logic                          s_first_of_chunk,
    input  brb_pkg::ctrl_t                ctrl,
    output brb_pkg::status_t              status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [brb_pkg::BYTE_W-1:0]    m_read_byte,
    output logic                          m_last,
    output logic                          m_accepted,
    output logic [brb_pkg::CNT_W-1:0]     m_used_count,
    output logic [brb_pkg::CNT_W-1:0]     m_free_count,
    output logic [brb_pkg::CNT_W-1:0]     m_contiguous_put,
    output logic [brb_pkg::CNT_W-1:0]     m_contiguous_get
);

    typedef struct packed {
        logic [brb_pkg::CNT_W-1:0] used;
        logic [brb_pkg::CNT_W-1:0] free;
        logic [brb_pkg::CNT_W-1:0] cput;
        logic [brb_pkg::CNT_W-1:0] cget;
    } cnt_t;

    localparam logic [brb_pkg::CALC_W-1:0] SLOTS_C = brb_pkg::CALC_W'(brb_pkg::SLOTS);
    localparam logic [brb_pkg::CALC_W-1:0] ONE_C   = brb_pkg::CALC_W'(1);
    localparam logic [brb_pkg::CALC_W-1:0] MAXRD_C =
        brb_pkg::CALC_W'(brb_pkg::MAX_READ_CHUNK);
    localparam logic [brb_pkg::IDX_W-1:0]  LAST_IDX = brb_pkg::IDX_W'(brb_pkg::SLOTS - 1);

    function automatic logic [brb_pkg::IDX_W-1:0] advance(
        input logic [brb_pkg::IDX_W-1:0] i);
        advance = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [brb_pkg::CALC_W-1:0] ext_idx(
        input logic [brb_pkg::IDX_W-1:0] i);
        ext_idx = {{(brb_pkg::CALC_W-brb_pkg::IDX_W){1'b0}}, i};
    endfunction

    function automatic logic [brb_pkg::CALC_W-1:0] used_of(
        input logic [brb_pkg::IDX_W-1:0] rd,
        input logic [brb_pkg::IDX_W-1:0] wr);
        if (wr >= rd) begin
            used_of = ext_idx(wr) - ext_idx(rd);
        end else begin
            used_of = ext_idx(wr) + SLOTS_C - ext_idx(rd);
        end
    endfunction

    function automatic cnt_t calc_counts(
        input logic [brb_pkg::IDX_W-1:0] rd,
        input logic [brb_pkg::IDX_W-1:0] wr);
        logic [brb_pkg::CALC_W-1:0] r;
        logic [brb_pkg::CALC_W-1:0] w;
        logic [brb_pkg::CALC_W-1:0] u;
        logic [brb_pkg::CALC_W-1:0] f;
        logic [brb_pkg::CALC_W-1:0] p;
        logic [brb_pkg::CALC_W-1:0] g;
        r = ext_idx(rd);
        w = ext_idx(wr);
        u = used_of(rd, wr);
        f = SLOTS_C - ONE_C - u;
        if (wr >= rd) begin
            // put run loses a slot only when the reader sits at slot zero
            p = (rd == '0) ? SLOTS_C - ONE_C - w : SLOTS_C - w;
            g = w - r;
        end else begin
            p = r - w - ONE_C;
            g = SLOTS_C - r;
        end
        calc_counts.used = u[brb_pkg::CNT_W-1:0];
        calc_counts.free = f[brb_pkg::CNT_W-1:0];
        calc_counts.cput = p[brb_pkg::CNT_W-1:0];
        calc_counts.cget = g[brb_pkg::CNT_W-1:0];
    endfunction

    logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::SLOTS];

    logic [brb_pkg::IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [brb_pkg::IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic                       chunk_acc_reg, chunk_acc_next;
    logic [brb_pkg::LEN_W-1:0]  chunk_rem_reg, chunk_rem_next;
    logic [brb_pkg::IDX_W-1:0]  ptr_reg;
    logic [brb_pkg::LEFT_W-1:0] left_reg;
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_last_reg;
    logic [brb_pkg::BYTE_W-1:0] mem_q_reg;
    logic                       out_valid_reg, out_valid_next;

    logic [brb_pkg::CALC_W-1:0] used_cur;
    logic [brb_pkg::CALC_W-1:0] len_ext;
    logic [brb_pkg::CALC_W-1:0] rd_sum;
    logic                       put_acc;
    logic [brb_pkg::LEN_W-1:0]  put_rem;
    logic                       store;
    logic                       out_free;
    logic                       s1_move;
    cnt_t                       cnt_next;

    assign out_free = !out_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign used_cur = used_of(rd_idx_reg, wr_idx_reg);
    assign len_ext  = {{(brb_pkg::CALC_W-brb_pkg::LEN_W){1'b0}}, s_length};
    assign rd_sum   = ext_idx(rd_idx_reg) + len_ext;

    assign status.s1_valid     = s1_valid_reg;
    assign status.s1_free_next = !s1_valid_reg || out_free;
    assign status.out_free     = out_free;
    assign status.read_len_ok  = (len_ext <= MAXRD_C) && (len_ext <= used_cur);
    assign status.len_zero     = (s_length == '0);
    assign status.left_last    = (left_reg == brb_pkg::LEFT_W'(1));

    always_comb begin
        // a first item reopens the chunk against the current free space
        if (s_first_of_chunk) begin
            put_acc = (len_ext <= SLOTS_C - ONE_C - used_cur);
            put_rem = put_acc ? s_length : '0;
        end else begin
            put_acc = chunk_acc_reg;
            put_rem = chunk_rem_reg;
        end
        store = ctrl.do_put && put_acc && (put_rem != '0);

        chunk_acc_next = chunk_acc_reg;
        chunk_rem_next = chunk_rem_reg;
        if (ctrl.do_put) begin
            chunk_acc_next = put_acc;
            chunk_rem_next = store ? put_rem - 1'b1 : put_rem;
        end

        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        if (store) begin
            wr_idx_next = advance(wr_idx_reg);
        end
        if (ctrl.do_clear) begin
            rd_idx_next = '0;
            wr_idx_next = '0;
        end
        if (ctrl.rd_commit) begin
            rd_idx_next = (rd_sum >= SLOTS_C) ? rd_sum[brb_pkg::IDX_W-1:0] -
                          LAST_IDX - 1'b1 : rd_sum[brb_pkg::IDX_W-1:0];
        end

        // every result reports the levels after its whole command
        cnt_next = calc_counts(rd_idx_next, wr_idx_next);

        if (ctrl.issue) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (ctrl.imm_load || s1_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            chunk_acc_reg <= 1'b0;
            chunk_rem_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            chunk_acc_reg <= chunk_acc_next;
            chunk_rem_reg <= chunk_rem_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            mem[wr_idx_reg] <= s_data_byte;
        end
        if (ctrl.issue) begin
            mem_q_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start_read) begin
            ptr_reg  <= rd_idx_reg;
            left_reg <= s_length[brb_pkg::LEFT_W-1:0];
        end else if (ctrl.issue) begin
            ptr_reg  <= advance(ptr_reg);
            left_reg <= left_reg - 1'b1;
        end
        if (ctrl.issue) begin
            s1_last_reg <= ctrl.issue_last;
        end
        if (ctrl.imm_load) begin
            m_read_byte      <= '0;
            m_last           <= 1'b1;
            m_accepted       <= ctrl.do_put ? store : ctrl.imm_acc;
            m_used_count     <= cnt_next.used;
            m_free_count     <= cnt_next.free;
            m_contiguous_put <= cnt_next.cput;
            m_contiguous_get <= cnt_next.cget;
        end else if (s1_move) begin
            m_read_byte      <= mem_q_reg;
            m_last           <= s1_last_reg;
            m_accepted       <= 1'b1;
            m_used_count     <= cnt_next.used;
            m_free_count     <= cnt_next.free;
            m_contiguous_put <= cnt_next.cput;
            m_contiguous_get <= cnt_next.cget;
        end
    end

    assign m_valid = out_valid_reg;

endmodule
